[rtl/mmhs_pkg.sv]
// ----------------------------------------------------------------------------
// mmhs_pkg
// Types and constants shared by the motor mode handshake sequencer.
// ----------------------------------------------------------------------------
package mmhs_pkg;

   // Item opcodes.
   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_RX_FRAME  = 2'd1,
      OP_CALIBRATE = 2'd2,
      OP_LINK_LOST = 2'd3
   } op_type;

   // Calibration machine phases; unused codes fall back to idle.
   typedef enum logic [2:0] {
      CAL_IDLE  = 3'd0,
      CAL_EN1   = 3'd1,
      CAL_WAIT1 = 3'd2,
      CAL_ZERO  = 3'd3,
      CAL_WAIT2 = 3'd4,
      CAL_EN2   = 3'd5
   } cal_phase_type;

   // Mode switch machine phases; unused codes fall back to idle.
   typedef enum logic [2:0] {
      SW_IDLE    = 3'd0,
      SW_SEND    = 3'd1,
      SW_GAP     = 3'd2,
      SW_READ    = 3'd3,
      SW_CONFIRM = 3'd4
   } switch_phase_type;

   // Which frame, if any, an item sends.
   typedef enum logic [2:0] {
      FRAME_NONE,
      FRAME_ENABLE,
      FRAME_ZERO,
      FRAME_MODE_WRITE,
      FRAME_READBACK
   } frame_type;

   // Drive modes as carried by the wanted mode and the active mode.
   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_TORQUE  = 2'd1;
   localparam logic [1:0] MODE_POS_VEL = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_WANTED_MODE   = 3'd0;
   localparam logic [2:0] CSR_MOTOR_ID      = 3'd1;
   localparam logic [2:0] CSR_SETTLE_TICKS  = 3'd2;
   localparam logic [2:0] CSR_RESEND_TICKS  = 3'd3;
   localparam logic [2:0] CSR_CONFIRM_TICKS = 3'd4;
   localparam logic [2:0] CSR_WRITE_REPEATS = 3'd5;
   localparam logic [2:0] CSR_ATTEMPT_LIMIT = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Frame constants.
   localparam logic [7:0]  CMD_ENABLE      = 8'hFC;
   localparam logic [7:0]  CMD_ZERO        = 8'hFE;
   localparam logic [10:0] BROADCAST_ID    = 11'h7FF;
   localparam logic [7:0]  REG_MODE        = 8'h0A;
   localparam logic [7:0]  REG_OP_WRITE    = 8'h55;
   localparam logic [7:0]  REG_OP_READ     = 8'h33;
   localparam logic [3:0]  FEEDBACK_NIBBLE = 4'h1;
   localparam logic [55:0] CMD_FILL        = 56'hFF_FFFF_FFFF_FFFF;
   localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;
   localparam logic [3:0]  ATTEMPTS_MAX    = 4'hF;

   typedef struct packed {
      logic [1:0]  wanted_mode;
      logic [10:0] motor_id;
      logic [15:0] settle_ticks;
      logic [15:0] resend_ticks;
      logic [15:0] confirm_ticks;
      logic [3:0]  write_repeats;
      logic [3:0]  attempt_limit;
   } config_type;

   typedef struct packed {
      cal_phase_type    cal_phase;
      logic             init_done;
      logic             init_waiting;
      switch_phase_type switch_phase;
      logic [1:0]       switch_target;
      logic [3:0]       writes_sent;
      logic [3:0]       attempts_made;
      logic [15:0]      elapsed;
      logic [1:0]       confirmed;
      logic [31:0]      last_read_mode;
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] rx_data;
   } req_payload_type;

   typedef struct packed {
      logic        tx_valid;
      logic [10:0] tx_id;
      logic [63:0] tx_data;
      logic        ready_res;
      logic [1:0]  active_mode;
   } rsp_payload_type;

endpackage

[rtl/motor_mode_handshake_sequencer.sv]
// ----------------------------------------------------------------------------
// motor_mode_handshake_sequencer
// Per-motor CAN bring-up sequencer: calibration, init and mode switch.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register; when the result side
// is free, the state update and the result register are written together
// (input register, then state update and result register).
// Throughput: one item per cycle while results are taken; the single state
// register update in the step logic is the only loop.
// Reset (synchronous, active high) empties both registers, returns all
// machines to idle and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module motor_mode_handshake_sequencer (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  mmhs_pkg::req_payload_type                req_payload,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output mmhs_pkg::rsp_payload_type                rsp_payload,
   input  logic                                     csr_we,
   input  logic [mmhs_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [mmhs_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   // Input register: holds one accepted item until it can be processed.
   logic                      in_valid_ff;
   logic                      in_valid_in;
   mmhs_pkg::req_payload_type in_item_ff;

   // Result register: holds the result until the consumer takes it.
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   mmhs_pkg::rsp_payload_type rsp_payload_ff;

   // Machine state and configuration.
   mmhs_pkg::state_type       state_ff;
   mmhs_pkg::state_type       state_in;
   mmhs_pkg::config_type      cfg_ff;
   mmhs_pkg::config_type      cfg_in;

   mmhs_pkg::rsp_payload_type step_result;
   logic                      advance;

   // The held item moves on whenever the result register is empty or is
   // being emptied this cycle. State and result are written together, so
   // the next item always sees the state the previous one left behind.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   mmhs_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (in_item_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   // Configuration writes; an index beyond the register list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            mmhs_pkg::CSR_WANTED_MODE:   cfg_in.wanted_mode   = csr_wdata[1:0];
            mmhs_pkg::CSR_MOTOR_ID:      cfg_in.motor_id      = csr_wdata[10:0];
            mmhs_pkg::CSR_SETTLE_TICKS:  cfg_in.settle_ticks  = csr_wdata;
            mmhs_pkg::CSR_RESEND_TICKS:  cfg_in.resend_ticks  = csr_wdata;
            mmhs_pkg::CSR_CONFIRM_TICKS: cfg_in.confirm_ticks = csr_wdata;
            mmhs_pkg::CSR_WRITE_REPEATS: cfg_in.write_repeats = csr_wdata[3:0];
            mmhs_pkg::CSR_ATTEMPT_LIMIT: cfg_in.attempt_limit = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{cal_phase: mmhs_pkg::CAL_IDLE,
                           switch_phase: mmhs_pkg::SW_IDLE,
                           default: '0};
         cfg_ff       <= '{wanted_mode: mmhs_pkg::MODE_TORQUE, motor_id: 11'd1,
                           settle_ticks: 16'd100, resend_ticks: 16'd10,
                           confirm_ticks: 16'd200, write_repeats: 4'd3,
                           attempt_limit: 4'd3};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= step_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The ready flag of a pending result matches the state it was built with.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_payload_ff.ready_res ==
         (state_ff.init_done && state_ff.switch_phase == mmhs_pkg::SW_IDLE &&
          state_ff.cal_phase == mmhs_pkg::CAL_IDLE))
      else $error("ready_res disagrees with the machine state");

   // A link-lost item sends an enable frame and drops init.
   assert property (@(posedge clock) disable iff (reset)
      advance && mmhs_pkg::op_type'(in_item_ff.op) == mmhs_pkg::OP_LINK_LOST |=>
         !state_ff.init_done && rsp_payload_ff.tx_valid && !rsp_payload_ff.ready_res)
      else $error("link-lost item did not restart init");

   // The confirmed mode only changes on a received frame.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && state_ff.confirmed != $past(state_ff.confirmed) |->
         $past(advance) &&
         $past(mmhs_pkg::op_type'(in_item_ff.op)) == mmhs_pkg::OP_RX_FRAME)
      else $error("confirmed mode changed without a readback reply");

   // The active mode reported always matches the confirmed state.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_payload_ff.active_mode == state_ff.confirmed)
      else $error("active_mode disagrees with the confirmed mode");

endmodule

[rtl/mmhs_step.sv]
// ----------------------------------------------------------------------------
// mmhs_step
// Next-state and result logic for one item of the sequencer.
// ----------------------------------------------------------------------------
module mmhs_step (
   input  mmhs_pkg::config_type      cfg,
   input  mmhs_pkg::state_type       state_cur,
   input  mmhs_pkg::req_payload_type item,
   output mmhs_pkg::state_type       state_nxt,
   output mmhs_pkg::rsp_payload_type result
);

   mmhs_pkg::frame_type frame;
   logic [15:0]         elapsed_inc;
   logic [3:0]          writes_inc;
   logic [3:0]          attempts_inc;
   logic [7:0]          b0;
   logic [7:0]          b2;
   logic [7:0]          b3;
   logic [31:0]         read_val;

   assign elapsed_inc  = (state_cur.elapsed < mmhs_pkg::ELAPSED_MAX) ?
                         state_cur.elapsed + 16'd1 : state_cur.elapsed;
   assign writes_inc   = state_cur.writes_sent + 4'd1;
   assign attempts_inc = (state_cur.attempts_made < mmhs_pkg::ATTEMPTS_MAX) ?
                         state_cur.attempts_made + 4'd1 : state_cur.attempts_made;
   assign b0       = item.rx_data[7:0];
   assign b2       = item.rx_data[23:16];
   assign b3       = item.rx_data[31:24];
   assign read_val = item.rx_data[63:32];

   // Next state and the kind of frame sent.
   always_comb begin
      state_nxt = state_cur;
      frame     = mmhs_pkg::FRAME_NONE;
      unique case (mmhs_pkg::op_type'(item.op))
         mmhs_pkg::OP_TICK: begin
            state_nxt.elapsed = elapsed_inc;
            if (state_cur.cal_phase != mmhs_pkg::CAL_IDLE) begin
               unique case (state_cur.cal_phase)
                  mmhs_pkg::CAL_EN1: begin
                     frame               = mmhs_pkg::FRAME_ENABLE;
                     state_nxt.cal_phase = mmhs_pkg::CAL_WAIT1;
                     state_nxt.elapsed   = '0;
                  end
                  mmhs_pkg::CAL_WAIT1: begin
                     if (elapsed_inc >= cfg.settle_ticks) begin
                        state_nxt.cal_phase = mmhs_pkg::CAL_ZERO;
                     end
                  end
                  mmhs_pkg::CAL_ZERO: begin
                     frame               = mmhs_pkg::FRAME_ZERO;
                     state_nxt.cal_phase = mmhs_pkg::CAL_WAIT2;
                     state_nxt.elapsed   = '0;
                  end
                  mmhs_pkg::CAL_WAIT2: begin
                     if (elapsed_inc >= cfg.settle_ticks) begin
                        state_nxt.cal_phase = mmhs_pkg::CAL_EN2;
                     end
                  end
                  mmhs_pkg::CAL_EN2: begin
                     frame               = mmhs_pkg::FRAME_ENABLE;
                     state_nxt.cal_phase = mmhs_pkg::CAL_IDLE;
                  end
                  default: state_nxt.cal_phase = mmhs_pkg::CAL_IDLE;
               endcase
            end else if (!state_cur.init_done) begin
               if (!state_cur.init_waiting) begin
                  frame                  = mmhs_pkg::FRAME_ENABLE;
                  state_nxt.init_waiting = 1'b1;
                  state_nxt.elapsed      = '0;
               end else if (elapsed_inc >= cfg.settle_ticks) begin
                  state_nxt.init_done    = 1'b1;
                  state_nxt.init_waiting = 1'b0;
               end
            end else begin
               unique case (state_cur.switch_phase)
                  mmhs_pkg::SW_IDLE: begin
                     if ((cfg.wanted_mode == mmhs_pkg::MODE_TORQUE ||
                          cfg.wanted_mode == mmhs_pkg::MODE_POS_VEL) &&
                         state_cur.confirmed != cfg.wanted_mode) begin
                        state_nxt.switch_phase  = mmhs_pkg::SW_SEND;
                        state_nxt.switch_target = cfg.wanted_mode;
                        state_nxt.writes_sent   = '0;
                        state_nxt.attempts_made = '0;
                     end
                  end
                  mmhs_pkg::SW_SEND: begin
                     if (state_cur.writes_sent < cfg.write_repeats) begin
                        frame                  = mmhs_pkg::FRAME_MODE_WRITE;
                        state_nxt.writes_sent  = writes_inc;
                        state_nxt.switch_phase = (writes_inc < cfg.write_repeats) ?
                                                 mmhs_pkg::SW_GAP : mmhs_pkg::SW_READ;
                        state_nxt.elapsed      = '0;
                     end else begin
                        state_nxt.switch_phase = mmhs_pkg::SW_READ;
                     end
                  end
                  mmhs_pkg::SW_GAP: begin
                     if (elapsed_inc >= cfg.resend_ticks) begin
                        state_nxt.switch_phase = mmhs_pkg::SW_SEND;
                     end
                  end
                  mmhs_pkg::SW_READ: begin
                     frame                  = mmhs_pkg::FRAME_READBACK;
                     state_nxt.switch_phase = mmhs_pkg::SW_CONFIRM;
                     state_nxt.elapsed      = '0;
                  end
                  mmhs_pkg::SW_CONFIRM: begin
                     if (elapsed_inc >= cfg.confirm_ticks) begin
                        state_nxt.attempts_made = attempts_inc;
                        if (attempts_inc < cfg.attempt_limit) begin
                           state_nxt.writes_sent  = '0;
                           state_nxt.switch_phase = mmhs_pkg::SW_SEND;
                        end else begin
                           state_nxt.switch_phase = mmhs_pkg::SW_IDLE;
                        end
                     end
                  end
                  default: state_nxt.switch_phase = mmhs_pkg::SW_IDLE;
               endcase
            end
         end
         mmhs_pkg::OP_RX_FRAME: begin
            // Motion feedback is dropped; only mode register replies count.
            if (b0[7:4] != mmhs_pkg::FEEDBACK_NIBBLE &&
                b2 == mmhs_pkg::REG_OP_READ && b3 == mmhs_pkg::REG_MODE) begin
               state_nxt.last_read_mode = read_val;
               if (state_cur.switch_phase == mmhs_pkg::SW_CONFIRM &&
                   read_val == {30'd0, state_cur.switch_target}) begin
                  state_nxt.confirmed    = state_cur.switch_target;
                  state_nxt.switch_phase = mmhs_pkg::SW_IDLE;
               end
            end
         end
         mmhs_pkg::OP_CALIBRATE: begin
            if (state_cur.cal_phase == mmhs_pkg::CAL_IDLE) begin
               state_nxt.cal_phase = mmhs_pkg::CAL_EN1;
            end
         end
         mmhs_pkg::OP_LINK_LOST: begin
            frame                  = mmhs_pkg::FRAME_ENABLE;
            state_nxt.init_done    = 1'b0;
            state_nxt.init_waiting = 1'b0;
            state_nxt.cal_phase    = mmhs_pkg::CAL_IDLE;
         end
      endcase
   end

   // Result fields from the frame kind and the updated state.
   always_comb begin
      result.tx_valid = 1'b1;
      result.tx_id    = cfg.motor_id;
      result.tx_data  = '0;
      unique case (frame)
         mmhs_pkg::FRAME_ENABLE: result.tx_data = {mmhs_pkg::CMD_ENABLE, mmhs_pkg::CMD_FILL};
         mmhs_pkg::FRAME_ZERO:   result.tx_data = {mmhs_pkg::CMD_ZERO, mmhs_pkg::CMD_FILL};
         mmhs_pkg::FRAME_MODE_WRITE: begin
            result.tx_id   = mmhs_pkg::BROADCAST_ID;
            result.tx_data = {24'd0, 6'd0, state_cur.switch_target, mmhs_pkg::REG_MODE,
                              mmhs_pkg::REG_OP_WRITE, 5'd0, cfg.motor_id[10:8],
                              cfg.motor_id[7:0]};
         end
         mmhs_pkg::FRAME_READBACK: begin
            result.tx_id   = mmhs_pkg::BROADCAST_ID;
            result.tx_data = {32'd0, mmhs_pkg::REG_MODE, mmhs_pkg::REG_OP_READ, 5'd0,
                              cfg.motor_id[10:8], cfg.motor_id[7:0]};
         end
         default: begin
            result.tx_valid = 1'b0;
            result.tx_id    = '0;
         end
      endcase
      result.ready_res   = state_nxt.init_done &&
                           state_nxt.switch_phase == mmhs_pkg::SW_IDLE &&
                           state_nxt.cal_phase == mmhs_pkg::CAL_IDLE;
      result.active_mode = state_nxt.confirmed;
   end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor mode handshake sequencer. A scoreboard
// class predicts the result of every accepted item from its own copy of the
// configuration and machine state. Tasks drive a directed bring-up sequence
// and then random phases, each under a fresh register setting.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // A wanted mode that names no drive mode.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Index seven is not a register; writes to it must change nothing.
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   localparam int RANDOM_ITEMS  = 1700;
   localparam int QUIET_FROM    = RANDOM_ITEMS - 200;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 4000;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts each result item and checks it against the block.
   // -------------------------------------------------------------------------
   class mode_sequencer_sb;
      mmhs_pkg::config_type       cfg;
      mmhs_pkg::cal_phase_type    cal_phase;
      logic                       init_done;
      logic                       init_waiting;
      mmhs_pkg::switch_phase_type switch_phase;
      logic [1:0]                 switch_target;
      logic [3:0]                 writes_sent;
      logic [3:0]                 attempts_made;
      logic [15:0]                elapsed;
      logic [1:0]                 confirmed;
      logic [31:0]                last_read_mode;

      mmhs_pkg::rsp_payload_type  frame_status_q[$];
      int errors;
      int items;
      int checked;
      int frames;
      int confirms;
      int cal_starts;

      function new();
         cfg = '{wanted_mode: mmhs_pkg::MODE_TORQUE, motor_id: 11'd1,
                 settle_ticks: 16'd100, resend_ticks: 16'd10, confirm_ticks: 16'd200,
                 write_repeats: 4'd3, attempt_limit: 4'd3};
         cal_phase      = mmhs_pkg::CAL_IDLE;
         init_done      = 1'b0;
         init_waiting   = 1'b0;
         switch_phase   = mmhs_pkg::SW_IDLE;
         switch_target  = mmhs_pkg::MODE_NONE;
         writes_sent    = '0;
         attempts_made  = '0;
         elapsed        = '0;
         confirmed      = mmhs_pkg::MODE_NONE;
         last_read_mode = '0;
      endfunction

      task report(string what);
         errors++;
         $display("ERROR: %s", what);
      endtask

      function void configure(logic [2:0] index, logic [15:0] data);
         case (index)
            mmhs_pkg::CSR_WANTED_MODE:   cfg.wanted_mode   = data[1:0];
            mmhs_pkg::CSR_MOTOR_ID:      cfg.motor_id      = data[10:0];
            mmhs_pkg::CSR_SETTLE_TICKS:  cfg.settle_ticks  = data;
            mmhs_pkg::CSR_RESEND_TICKS:  cfg.resend_ticks  = data;
            mmhs_pkg::CSR_CONFIRM_TICKS: cfg.confirm_ticks = data;
            mmhs_pkg::CSR_WRITE_REPEATS: cfg.write_repeats = data[3:0];
            mmhs_pkg::CSR_ATTEMPT_LIMIT: cfg.attempt_limit = data[3:0];
            default: ;
         endcase
      endfunction

      // Enable and zero commands go out on the motor's own identifier.
      function void send_command(inout mmhs_pkg::rsp_payload_type r,
                                 input logic [7:0] cmd);
         r.tx_valid = 1'b1;
         r.tx_id    = cfg.motor_id;
         r.tx_data  = {cmd, mmhs_pkg::CMD_FILL};
         frames++;
      endfunction

      // Mode register writes and readback requests go out on the broadcast id.
      function void send_register(inout mmhs_pkg::rsp_payload_type r,
                                  input logic [7:0] op_byte, input logic [7:0] value);
         r.tx_valid = 1'b1;
         r.tx_id    = mmhs_pkg::BROADCAST_ID;
         r.tx_data  = {24'h0, value, mmhs_pkg::REG_MODE, op_byte, 5'b0,
                       cfg.motor_id[10:8], cfg.motor_id[7:0]};
         frames++;
      endfunction

      function mmhs_pkg::rsp_payload_type run_item(mmhs_pkg::op_type op, logic [63:0] rx);
         mmhs_pkg::rsp_payload_type r;
         r = '0;
         case (op)
            mmhs_pkg::OP_TICK: begin
               if (elapsed != mmhs_pkg::ELAPSED_MAX) elapsed++;
               if (cal_phase != mmhs_pkg::CAL_IDLE) begin
                  case (cal_phase)
                     mmhs_pkg::CAL_EN1: begin
                        send_command(r, mmhs_pkg::CMD_ENABLE);
                        cal_phase = mmhs_pkg::CAL_WAIT1;
                        elapsed = '0;
                     end
                     mmhs_pkg::CAL_WAIT1: begin
                        if (elapsed >= cfg.settle_ticks) cal_phase = mmhs_pkg::CAL_ZERO;
                     end
                     mmhs_pkg::CAL_ZERO: begin
                        send_command(r, mmhs_pkg::CMD_ZERO);
                        cal_phase = mmhs_pkg::CAL_WAIT2;
                        elapsed = '0;
                     end
                     mmhs_pkg::CAL_WAIT2: begin
                        if (elapsed >= cfg.settle_ticks) cal_phase = mmhs_pkg::CAL_EN2;
                     end
                     mmhs_pkg::CAL_EN2: begin
                        send_command(r, mmhs_pkg::CMD_ENABLE);
                        cal_phase = mmhs_pkg::CAL_IDLE;
                     end
                     default: cal_phase = mmhs_pkg::CAL_IDLE;
                  endcase
               end else if (!init_done) begin
                  if (!init_waiting) begin
                     send_command(r, mmhs_pkg::CMD_ENABLE);
                     init_waiting = 1'b1;
                     elapsed = '0;
                  end else if (elapsed >= cfg.settle_ticks) begin
                     init_done = 1'b1;
                     init_waiting = 1'b0;
                  end
               end else begin
                  case (switch_phase)
                     mmhs_pkg::SW_IDLE: begin
                        if ((cfg.wanted_mode == mmhs_pkg::MODE_TORQUE ||
                             cfg.wanted_mode == mmhs_pkg::MODE_POS_VEL) &&
                            confirmed != cfg.wanted_mode) begin
                           switch_phase  = mmhs_pkg::SW_SEND;
                           switch_target = cfg.wanted_mode;
                           writes_sent   = '0;
                           attempts_made = '0;
                        end
                     end
                     mmhs_pkg::SW_SEND: begin
                        if (writes_sent < cfg.write_repeats) begin
                           send_register(r, mmhs_pkg::REG_OP_WRITE, {6'b0, switch_target});
                           writes_sent++;
                           switch_phase = (writes_sent < cfg.write_repeats) ?
                                          mmhs_pkg::SW_GAP : mmhs_pkg::SW_READ;
                           elapsed = '0;
                        end else begin
                           switch_phase = mmhs_pkg::SW_READ;
                        end
                     end
                     mmhs_pkg::SW_GAP: begin
                        if (elapsed >= cfg.resend_ticks) switch_phase = mmhs_pkg::SW_SEND;
                     end
                     mmhs_pkg::SW_READ: begin
                        send_register(r, mmhs_pkg::REG_OP_READ, 8'h00);
                        switch_phase = mmhs_pkg::SW_CONFIRM;
                        elapsed = '0;
                     end
                     mmhs_pkg::SW_CONFIRM: begin
                        if (elapsed >= cfg.confirm_ticks) begin
                           if (attempts_made != mmhs_pkg::ATTEMPTS_MAX) attempts_made++;
                           if (attempts_made < cfg.attempt_limit) begin
                              writes_sent = '0;
                              switch_phase = mmhs_pkg::SW_SEND;
                           end else begin
                              switch_phase = mmhs_pkg::SW_IDLE;
                           end
                        end
                     end
                     default: switch_phase = mmhs_pkg::SW_IDLE;
                  endcase
               end
            end
            mmhs_pkg::OP_RX_FRAME: begin
               // Motion feedback is ignored; only a mode readback reply counts.
               if (rx[7:4] != mmhs_pkg::FEEDBACK_NIBBLE &&
                   rx[23:16] == mmhs_pkg::REG_OP_READ &&
                   rx[31:24] == mmhs_pkg::REG_MODE) begin
                  last_read_mode = rx[63:32];
                  if (switch_phase == mmhs_pkg::SW_CONFIRM &&
                      rx[63:32] == {30'b0, switch_target}) begin
                     confirmed = switch_target;
                     switch_phase = mmhs_pkg::SW_IDLE;
                     confirms++;
                  end
               end
            end
            mmhs_pkg::OP_CALIBRATE: begin
               if (cal_phase == mmhs_pkg::CAL_IDLE) begin
                  cal_phase = mmhs_pkg::CAL_EN1;
                  cal_starts++;
               end
            end
            default: begin
               send_command(r, mmhs_pkg::CMD_ENABLE);
               init_done = 1'b0;
               init_waiting = 1'b0;
               cal_phase = mmhs_pkg::CAL_IDLE;
            end
         endcase
         r.ready_res   = init_done && switch_phase == mmhs_pkg::SW_IDLE &&
                         cal_phase == mmhs_pkg::CAL_IDLE;
         r.active_mode = confirmed;
         return r;
      endfunction

      function void note_item(mmhs_pkg::op_type op, logic [63:0] rx);
         frame_status_q.push_back(run_item(op, rx));
         items++;
      endfunction

      function int pending();
         return frame_status_q.size();
      endfunction

      task check_response(mmhs_pkg::rsp_payload_type got);
         mmhs_pkg::rsp_payload_type want;
         string diff;
         if (frame_status_q.size() == 0) begin
            report($sformatf("result with no item waiting: tx %b id %h data %h",
                             got.tx_valid, got.tx_id, got.tx_data));
            return;
         end
         want = frame_status_q.pop_front();
         checked++;
         diff = "";
         if (got.tx_valid !== want.tx_valid)       diff = {diff, " tx_valid"};
         if (got.tx_id !== want.tx_id)             diff = {diff, " tx_id"};
         if (got.tx_data !== want.tx_data)         diff = {diff, " tx_data"};
         if (got.ready_res !== want.ready_res)     diff = {diff, " ready_res"};
         if (got.active_mode !== want.active_mode) diff = {diff, " active_mode"};
         if (diff != "")
            report($sformatf("result %0d differs in%s: got %b/%h/%h/%b/%0d want %b/%h/%h/%b/%0d",
                             checked, diff, got.tx_valid, got.tx_id, got.tx_data,
                             got.ready_res, got.active_mode, want.tx_valid, want.tx_id,
                             want.tx_data, want.ready_res, want.active_mode));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals and the block under test.
   // -------------------------------------------------------------------------
   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   mmhs_pkg::req_payload_type req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   mmhs_pkg::rsp_payload_type rsp_payload;
   logic                      csr_we;
   logic [2:0]                csr_index;
   logic [15:0]               csr_wdata;

   mode_sequencer_sb sb;

   // Flags shared between the stimulus and the receiver process.
   bit quiet;
   bit rsp_bursty;
   bit hold_request;

   motor_mode_handshake_sequencer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #1 clock = ~clock;

   // -------------------------------------------------------------------------
   // Driving tasks. Inputs change on the falling edge; the handshake is
   // sampled on the rising edge.
   // -------------------------------------------------------------------------

   // Offers one item and holds it until the block takes it. The valid stays
   // high afterwards, so the caller either offers the next item or idles at
   // the following falling edge.
   task send_item(mmhs_pkg::op_type op, logic [63:0] rx);
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload.op <= op;
      req_payload.rx_data <= rx;
      do @(posedge clock); while (!req_ready);
      sb.note_item(op, rx);
   endtask

   task idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task write_csr(logic [2:0] index, logic [15:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.configure(index, data);
   endtask

   // Writes every register. With junk set the unused upper data bits carry
   // random values, and the unused index is written as well.
   task program_config(mmhs_pkg::config_type c, bit junk);
      logic [15:0] pad;
      pad = junk ? 16'($urandom) : 16'h0;
      write_csr(mmhs_pkg::CSR_WANTED_MODE, {pad[15:2], c.wanted_mode});
      write_csr(mmhs_pkg::CSR_MOTOR_ID, {pad[15:11], c.motor_id});
      write_csr(mmhs_pkg::CSR_SETTLE_TICKS, c.settle_ticks);
      write_csr(mmhs_pkg::CSR_RESEND_TICKS, c.resend_ticks);
      write_csr(mmhs_pkg::CSR_CONFIRM_TICKS, c.confirm_ticks);
      write_csr(mmhs_pkg::CSR_WRITE_REPEATS, {pad[15:4], c.write_repeats});
      write_csr(mmhs_pkg::CSR_ATTEMPT_LIMIT, {pad[15:4], c.attempt_limit});
      if (junk) write_csr(CSR_UNUSED, pad);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Stops offering, lets every expected result come back, then gives the
   // pipeline time to settle before the registers may be touched.
   task drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [63:0] random_word();
      return {32'($urandom), 32'($urandom)};
   endfunction

   // Wait lengths: mostly short so that the machines cycle often, sometimes
   // zero or the largest value.
   function automatic logic [15:0] pick_ticks(int hi);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'hFFFF;
      if (r == 1) return 16'h0;
      return 16'($urandom_range(1, hi));
   endfunction

   function automatic logic [3:0] pick_count();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 4'hF;
      if (r == 1) return 4'h0;
      return 4'($urandom_range(1, 4));
   endfunction

   function automatic mmhs_pkg::config_type random_config();
      mmhs_pkg::config_type c;
      if ($urandom_range(0, 9) < 8)
         c.wanted_mode = $urandom_range(0, 1) ? mmhs_pkg::MODE_POS_VEL
                                              : mmhs_pkg::MODE_TORQUE;
      else
         c.wanted_mode = $urandom_range(0, 1) ? MODE_UNUSED : mmhs_pkg::MODE_NONE;
      case ($urandom_range(0, 7))
         0:       c.motor_id = 11'h000;
         1:       c.motor_id = mmhs_pkg::BROADCAST_ID;
         default: c.motor_id = 11'($urandom);
      endcase
      c.settle_ticks  = pick_ticks(6);
      c.resend_ticks  = pick_ticks(4);
      c.confirm_ticks = pick_ticks(12);
      c.write_repeats = pick_count();
      c.attempt_limit = pick_count();
      return c;
   endfunction

   // Received frames: mostly mode readback replies, most of them carrying the
   // mode being switched to, plus feedback frames, near misses and noise.
   function automatic logic [63:0] make_rx();
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [31:0] val;
      int kind;
      b0 = 8'($urandom);
      b1 = 8'($urandom);
      kind = $urandom_range(0, 9);
      if (b0[7:4] == mmhs_pkg::FEEDBACK_NIBBLE) b0[7:4] = 4'h0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: val = {30'b0, sb.switch_target};
         6, 7:             val = 32'($urandom_range(0, 3));
         default:          val = $urandom;
      endcase
      case (kind)
         0, 1, 2, 3, 4, 5:
            return {val, mmhs_pkg::REG_MODE, mmhs_pkg::REG_OP_READ, b1, b0};
         6:
            return {val, mmhs_pkg::REG_MODE, mmhs_pkg::REG_OP_READ, b1,
                    mmhs_pkg::FEEDBACK_NIBBLE, b0[3:0]};
         7:
            return {val, 8'($urandom), mmhs_pkg::REG_OP_READ, b1, b0};
         8:
            return {val, mmhs_pkg::REG_MODE, 8'($urandom), b1, b0};
         default:
            return random_word();
      endcase
   endfunction

   task random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 62)      send_item(mmhs_pkg::OP_TICK, random_word());
      else if (r < 88) send_item(mmhs_pkg::OP_RX_FRAME, make_rx());
      else if (r < 94) send_item(mmhs_pkg::OP_CALIBRATE, random_word());
      else             send_item(mmhs_pkg::OP_LINK_LOST, random_word());
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random ready bursts, one long hold-off on request, and a
   // steady ready in the quiet tail of the run and in phases without bursts.
   // -------------------------------------------------------------------------
   initial begin
      int hold_left;
      int low_left;
      hold_left = 0;
      low_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (quiet || !rsp_bursty) begin
            rsp_ready <= 1'b1;
         end else if (low_left > 0) begin
            rsp_ready <= 1'b0;
            low_left--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            low_left = $urandom_range(0, 15);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every accepted result is checked against the oldest prediction.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);
      end
   end

   // The watchdog ends the run if no item moves on either side for too long.
   initial begin
      int unsigned stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("ERROR: no item accepted for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int phase;
      int random_sent;
      int n;
      bit sender_bursty;

      sb = new();
      phase = 0;
      random_sent = 0;
      quiet = 1'b0;
      rsp_bursty = 1'b1;
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Under the reset settings the first tick starts init with an enable
      // frame on the default identifier.
      send_item(mmhs_pkg::OP_TICK, 64'h0);
      drain_block();

      // Directed bring-up with the shortest waits: init finishes, the switch
      // runs one attempt, ignores a feedback frame and a wrong readback, gives
      // up at the attempt limit, restarts and is then confirmed.
      program_config('{wanted_mode: mmhs_pkg::MODE_POS_VEL,
                       motor_id: mmhs_pkg::BROADCAST_ID,
                       settle_ticks: 16'd1, resend_ticks: 16'd1, confirm_ticks: 16'd1,
                       write_repeats: 4'd2, attempt_limit: 4'd1}, 1'b0);
      phase++;
      repeat (6) send_item(mmhs_pkg::OP_TICK, 64'h0);
      send_item(mmhs_pkg::OP_RX_FRAME, {30'b0, mmhs_pkg::MODE_POS_VEL, mmhs_pkg::REG_MODE,
                                        mmhs_pkg::REG_OP_READ, 8'h00,
                                        mmhs_pkg::FEEDBACK_NIBBLE, 4'hF});
      send_item(mmhs_pkg::OP_RX_FRAME, {30'b0, mmhs_pkg::MODE_TORQUE, mmhs_pkg::REG_MODE,
                                        mmhs_pkg::REG_OP_READ, 8'h00, 8'h00});
      repeat (6) send_item(mmhs_pkg::OP_TICK, 64'h0);
      send_item(mmhs_pkg::OP_RX_FRAME, {30'b0, mmhs_pkg::MODE_POS_VEL, mmhs_pkg::REG_MODE,
                                        mmhs_pkg::REG_OP_READ, 8'hFF, 8'h2A});

      // A calibrate request while one is pending is ignored; then the whole
      // calibration runs, and a link-lost event drops init again.
      send_item(mmhs_pkg::OP_CALIBRATE, 64'h0);
      send_item(mmhs_pkg::OP_CALIBRATE, 64'hFFFF_FFFF_FFFF_FFFF);
      repeat (5) send_item(mmhs_pkg::OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(mmhs_pkg::OP_LINK_LOST, 64'h0);
      send_item(mmhs_pkg::OP_RX_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(mmhs_pkg::OP_RX_FRAME, 64'h0);
      send_item(mmhs_pkg::OP_TICK, 64'h0);

      // Random phases, each with a new register setting.
      while (random_sent < RANDOM_ITEMS) begin
         drain_block();
         program_config(random_config(), $urandom_range(0, 2) == 0);
         phase++;
         sender_bursty = $urandom_range(0, 2) != 0;
         rsp_bursty = $urandom_range(0, 2) != 0;
         // In the second random phase the receiver stops for a long stretch
         // while items keep coming, so the block backs up and stalls its input.
         if (phase == 3) begin
            hold_request = 1'b1;
            sender_bursty = 1'b0;
         end
         n = $urandom_range(80, 160);
         repeat (n) begin
            if (random_sent >= QUIET_FROM) begin
               quiet = 1'b1;
               sender_bursty = 1'b0;
            end
            if (sender_bursty && $urandom_range(0, 7) == 0)
               idle_sender($urandom_range(1, 16));
            random_item();
            random_sent++;
         end
      end

      drain_block();
      repeat (8) @(posedge clock);

      $display("Ran %0d items through %0d register settings; %0d results checked.",
               sb.items, phase, sb.checked);
      $display("Predicted %0d frames, %0d mode confirmations, %0d calibrations.",
               sb.frames, sb.confirms, sb.cal_starts);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
